// ===== hdl/lpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpsf_pkg
// Widths, register indexes, tag codes and the time scaling constant shared by
// the lidar point stream filter.
// ----------------------------------------------------------------------------
package lpsf_pkg;

	localparam int BlindBits = 48;
	localparam int CountBits = 8;
	localparam int LineBits  = 8;
	localparam int TagBits   = 8;
	localparam int ReflBits  = 8;
	localparam int NsBits    = 32;
	localparam int TimeBits  = 29;
	localparam int CfgIdxBits = 2;

	localparam logic [CfgIdxBits-1:0] RegBlind = 2'd0;
	localparam logic [CfgIdxBits-1:0] RegKeep  = 2'd1;
	localparam logic [CfgIdxBits-1:0] RegLines = 2'd2;

	localparam logic [BlindBits-1:0] BlindReset = 48'd100;
	localparam logic [CountBits-1:0] KeepReset  = 8'd1;
	localparam logic [LineBits-1:0]  LinesReset = 8'd6;

	localparam int TagKindLsb = 4;
	localparam int TagKindMsb = 5;
	localparam logic [1:0] TagKindFirst  = 2'b00;
	localparam logic [1:0] TagKindSecond = 2'b01;

	// ns * 65536 / 1e6 == ns * 1024 / 15625 == (ns * TimeRecip) >> TimeShift
	localparam int TimeRecipBits = 43;
	localparam int RecipLoBits   = 22;
	localparam int RecipHiBits   = TimeRecipBits - RecipLoBits;
	localparam int TimeProdBits  = NsBits + TimeRecipBits;
	localparam int TimeShift     = 46;
	localparam logic [TimeRecipBits-1:0] TimeRecip = 43'd4611686018428;
	localparam logic [RecipLoBits-1:0] TimeRecipLo = TimeRecip[RecipLoBits-1:0];
	localparam logic [RecipHiBits-1:0] TimeRecipHi = TimeRecip[TimeRecipBits-1:RecipLoBits];

	typedef struct packed {
		logic load_mid;
		logic load_out;
	} lpsf_adv_t;

endpackage

// ===== hdl/lpsf_gate.sv =====
// ----------------------------------------------------------------------------
// lpsf_gate
// Frame, line and tag screening, decimation counter and stored previous point.
// ----------------------------------------------------------------------------
module lpsf_gate #(
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lpsf_pkg::CountBits-1:0] keep_every,
	input  logic [lpsf_pkg::LineBits-1:0]  line_count,
	input  logic                          item_go,
	input  logic                          frame_start,
	input  logic [lpsf_pkg::TagBits-1:0]   tag_bits,
	input  logic [lpsf_pkg::LineBits-1:0]  scan_line,
	input  logic signed [COORD_BITS-1:0]  pos_x,
	input  logic signed [COORD_BITS-1:0]  pos_y,
	input  logic signed [COORD_BITS-1:0]  pos_z,
	output logic                          cand
);
	import lpsf_pkg::*;

	logic [CountBits-1:0]  accept_count_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic [COORD_BITS-1:0] last_z_q;

	logic [1:0]           kind;
	logic                 accepted;
	logic [CountBits-1:0] n_eff;
	logic [CountBits-1:0] cnt_next;
	logic                 kept;
	logic                 differs;

	assign kind     = tag_bits[TagKindMsb:TagKindLsb];
	assign accepted = (scan_line < line_count) &&
		(kind == TagKindFirst || kind == TagKindSecond);
	assign n_eff    = (keep_every == '0) ? CountBits'(1) : keep_every;
	assign cnt_next = accept_count_q + CountBits'(1);
	assign kept     = !frame_start && accepted && (cnt_next >= n_eff);
	assign differs  = ($unsigned(pos_x) != last_x_q) || ($unsigned(pos_y) != last_y_q) ||
		($unsigned(pos_z) != last_z_q);
	assign cand     = kept && differs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_count_q <= '0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			last_z_q       <= '0;
		end else if (item_go) begin
			if (frame_start) begin
				accept_count_q <= '0;
				last_x_q       <= '0;
				last_y_q       <= '0;
				last_z_q       <= '0;
			end else if (!accepted) begin
				last_x_q <= '0;
				last_y_q <= '0;
				last_z_q <= '0;
			end else if (!kept) begin
				accept_count_q <= cnt_next;
				last_x_q       <= '0;
				last_y_q       <= '0;
				last_z_q       <= '0;
			end else begin
				accept_count_q <= '0;
				last_x_q       <= $unsigned(pos_x);
				last_y_q       <= $unsigned(pos_y);
				last_z_q       <= $unsigned(pos_z);
			end
		end
	end

	a_frame_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_go && frame_start |=> accept_count_q == '0 && last_x_q == '0 &&
			last_y_q == '0 && last_z_q == '0)
		else $error("frame start did not clear filter state");

	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_go && !kept |=> last_x_q == '0 && last_y_q == '0 && last_z_q == '0)
		else $error("stored point not cleared after a dropped item");

endmodule

// ===== hdl/lpsf_range.sv =====
// ----------------------------------------------------------------------------
// lpsf_range
// Squared range of a point against the blind radius: squares, then sum and
// compare.
// ----------------------------------------------------------------------------
module lpsf_range #(
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  lpsf_pkg::lpsf_adv_t           adv,
	input  logic signed [COORD_BITS-1:0]  pos_x,
	input  logic signed [COORD_BITS-1:0]  pos_y,
	input  logic signed [COORD_BITS-1:0]  pos_z,
	input  logic [lpsf_pkg::BlindBits-1:0] blind_radius_sq,
	output logic                          range_ok
);
	import lpsf_pkg::*;

	localparam int SqBits  = 2 * COORD_BITS;
	localparam int CmpBits = (SqBits > BlindBits) ? SqBits : BlindBits;

	logic [COORD_BITS-1:0] mag_x;
	logic [COORD_BITS-1:0] mag_y;
	logic [COORD_BITS-1:0] mag_z;
	logic [SqBits-1:0]     sq_x_s2;
	logic [SqBits-1:0]     sq_y_s2;
	logic [SqBits-1:0]     sq_z_s2;
	logic [SqBits-1:0]     range_sq;

	assign mag_x = pos_x[COORD_BITS-1] ? ('0 - $unsigned(pos_x)) : $unsigned(pos_x);
	assign mag_y = pos_y[COORD_BITS-1] ? ('0 - $unsigned(pos_y)) : $unsigned(pos_y);
	assign mag_z = pos_z[COORD_BITS-1] ? ('0 - $unsigned(pos_z)) : $unsigned(pos_z);

	always_ff @(posedge clk) begin
		if (adv.load_mid) begin
			sq_x_s2 <= SqBits'(mag_x) * SqBits'(mag_x);
			sq_y_s2 <= SqBits'(mag_y) * SqBits'(mag_y);
			sq_z_s2 <= SqBits'(mag_z) * SqBits'(mag_z);
		end
	end

	assign range_sq = sq_x_s2 + sq_y_s2 + sq_z_s2;
	assign range_ok = CmpBits'(range_sq) > CmpBits'(blind_radius_sq);

endmodule

// ===== hdl/lpsf_time.sv =====
// ----------------------------------------------------------------------------
// lpsf_time
// Offset time from nanoseconds to milliseconds in Q16 by reciprocal multiply,
// split into two partial products.
// ----------------------------------------------------------------------------
module lpsf_time (
	input  logic                          clk,
	input  lpsf_pkg::lpsf_adv_t           adv,
	input  logic [lpsf_pkg::NsBits-1:0]    offset_ns,
	output logic [lpsf_pkg::TimeBits-1:0]  time_ms_q16
);
	import lpsf_pkg::*;

	localparam int HiProdBits = NsBits + RecipHiBits;
	localparam int LoProdBits = NsBits + RecipLoBits;

	logic [HiProdBits-1:0]   p_hi_s2;
	logic [LoProdBits-1:0]   p_lo_s2;
	logic [TimeProdBits-1:0] prod;
	logic [TimeBits-1:0]     time_s3;

	always_ff @(posedge clk) begin
		if (adv.load_mid) begin
			p_hi_s2 <= HiProdBits'(offset_ns) * HiProdBits'(TimeRecipHi);
			p_lo_s2 <= LoProdBits'(offset_ns) * LoProdBits'(TimeRecipLo);
		end
	end

	assign prod = (TimeProdBits'(p_hi_s2) << RecipLoBits) + TimeProdBits'(p_lo_s2);

	always_ff @(posedge clk) begin
		if (adv.load_out) begin
			time_s3 <= prod[TimeShift +: TimeBits];
		end
	end

	assign time_ms_q16 = time_s3;

endmodule

// ===== hdl/lidar_point_stream_filter.sv =====
// ----------------------------------------------------------------------------
// lidar_point_stream_filter
// Drops frame starts, off-range lines and unwanted return kinds, decimates
// the accepted points, and emits kept points that moved and lie outside the
// blind radius, with their offset time in milliseconds (Q16).
// ----------------------------------------------------------------------------
// Takes one point per clock while in_stall is low and holds three register
// ranks: the input register, where the screening and decimation decision is
// made against the stored previous point; the square and partial-product
// register; and the result register after the range compare and time sum.
// A result is offered once its point has passed the input and square ranks.
// While the result register is stalled, input is still taken as long as an
// earlier rank is free. There is no start-up clearing pass.
module lidar_point_stream_filter #(
	parameter int COORD_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [lpsf_pkg::CfgIdxBits-1:0] cfg_index,
	input  logic [lpsf_pkg::BlindBits-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           frame_start,
	input  logic signed [COORD_BITS-1:0]   pos_x,
	input  logic signed [COORD_BITS-1:0]   pos_y,
	input  logic signed [COORD_BITS-1:0]   pos_z,
	input  logic [lpsf_pkg::ReflBits-1:0]   reflect,
	input  logic [lpsf_pkg::TagBits-1:0]    tag_bits,
	input  logic [lpsf_pkg::LineBits-1:0]   scan_line,
	input  logic [lpsf_pkg::NsBits-1:0]     offset_ns,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [COORD_BITS-1:0]   out_x,
	output logic signed [COORD_BITS-1:0]   out_y,
	output logic signed [COORD_BITS-1:0]   out_z,
	output logic [lpsf_pkg::ReflBits-1:0]   out_intensity,
	output logic [lpsf_pkg::TimeBits-1:0]   time_ms_q16
);
	import lpsf_pkg::*;

	logic [BlindBits-1:0] blind_radius_sq_q;
	logic [CountBits-1:0] keep_every_q;
	logic [LineBits-1:0]  line_count_q;

	logic                         v_s1;
	logic                         frame_start_s1;
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic signed [COORD_BITS-1:0] z_s1;
	logic [ReflBits-1:0]          refl_s1;
	logic [TagBits-1:0]           tag_s1;
	logic [LineBits-1:0]          line_s1;
	logic [NsBits-1:0]            ns_s1;

	logic                         v_s2;
	logic signed [COORD_BITS-1:0] x_s2;
	logic signed [COORD_BITS-1:0] y_s2;
	logic signed [COORD_BITS-1:0] z_s2;
	logic [ReflBits-1:0]          refl_s2;

	logic                         v_s3;
	logic signed [COORD_BITS-1:0] x_s3;
	logic signed [COORD_BITS-1:0] y_s3;
	logic signed [COORD_BITS-1:0] z_s3;
	logic [ReflBits-1:0]          refl_s3;

	lpsf_adv_t adv;
	logic      load_in;
	logic      cand;
	logic      range_ok;

	assign adv.load_out = !v_s3 || !out_stall;
	assign adv.load_mid = !v_s2 || adv.load_out;
	assign load_in      = !v_s1 || adv.load_mid;
	assign in_stall     = !load_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blind_radius_sq_q <= BlindReset;
			keep_every_q      <= KeepReset;
			line_count_q      <= LinesReset;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				RegBlind: blind_radius_sq_q <= cfg_data;
				RegKeep:  keep_every_q      <= cfg_data[CountBits-1:0];
				RegLines: line_count_q      <= cfg_data[LineBits-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (load_in)
				v_s1 <= in_valid;
			if (adv.load_mid)
				v_s2 <= v_s1 && cand;
			if (adv.load_out)
				v_s3 <= v_s2 && range_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			frame_start_s1 <= frame_start;
			x_s1           <= pos_x;
			y_s1           <= pos_y;
			z_s1           <= pos_z;
			refl_s1        <= reflect;
			tag_s1         <= tag_bits;
			line_s1        <= scan_line;
			ns_s1          <= offset_ns;
		end
		if (adv.load_mid) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			refl_s2 <= refl_s1;
		end
		if (adv.load_out) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
			refl_s3 <= refl_s2;
		end
	end

	lpsf_gate #(
		.COORD_BITS(COORD_BITS)
	) u_gate (
		.clk         (clk),
		.arst_n      (arst_n),
		.keep_every  (keep_every_q),
		.line_count  (line_count_q),
		.item_go     (v_s1 && adv.load_mid),
		.frame_start (frame_start_s1),
		.tag_bits    (tag_s1),
		.scan_line   (line_s1),
		.pos_x       (x_s1),
		.pos_y       (y_s1),
		.pos_z       (z_s1),
		.cand        (cand)
	);

	lpsf_range #(
		.COORD_BITS(COORD_BITS)
	) u_range (
		.clk             (clk),
		.adv             (adv),
		.pos_x           (x_s1),
		.pos_y           (y_s1),
		.pos_z           (z_s1),
		.blind_radius_sq (blind_radius_sq_q),
		.range_ok        (range_ok)
	);

	lpsf_time u_time (
		.clk         (clk),
		.adv         (adv),
		.offset_ns   (ns_s1),
		.time_ms_q16 (time_ms_q16)
	);

	assign out_valid     = v_s3;
	assign out_x         = x_s3;
	assign out_y         = y_s3;
	assign out_z         = z_s3;
	assign out_intensity = refl_s3;

	a_out_from_mid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s2))
		else $error("result appeared without a candidate in the middle stage");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> v_s1)
		else $error("input stage lost an item while stalled");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !v_s2 |=> !out_valid)
		else $error("result repeated after it was taken");

endmodule
